>>> src/tpsrt_pkg.sv
// Shared types and constants for the timed priority speed request table.
// Used by the top level and by the entry memory; depends on nothing.
`default_nettype none

package tpsrt_pkg;

    localparam int SPEED_W = 8;
    localparam int MIN_W   = 16;
    localparam int MS_W    = 32;

    localparam logic [SPEED_W-1:0] FALLBACK_RESET = 8'd42;
    localparam logic [MS_W-1:0]    MS_PER_MIN     = 32'd60000;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0]    rem_ms;
        logic [SPEED_W-1:0] speed;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

`default_nettype wire

>>> src/tpsrt_mem.sv
// Entry memory: speed and remaining time of each table slot.
// One write port, one read port with registered read data; uses tpsrt_pkg.
`default_nettype none

module tpsrt_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  tpsrt_pkg::t_entry    i_wdata,
    input  wire [AW-1:0]         i_raddr,
    output tpsrt_pkg::t_entry    o_rdata
);

    tpsrt_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/timed_priority_speed_request_table.sv
// Timed priority speed request table: top level with sequencer and output register.
// Depends on tpsrt_pkg and tpsrt_mem.
//
// Usage:
//   Input stream s_axis: tuser = kind (0 add, 1 tick); tdata = speed_value,
//   valid_minutes, clears_queue. Output stream m_axis: one word per input word
//   with accepted, current_speed and speed_changed.
//   Slot speeds and remaining times live in a one-port-read memory; live bits
//   are flip-flops. A tick or an add to a full table walks the memory once,
//   one entry per cycle, reading entry k while writing back entry k-1.
//   An add with zero duration or a free slot goes from accept straight to the
//   finish state and the output register; a tick or an add to a full table
//   first walks the memory. One item is in flight at a time; the next word is
//   taken the cycle after the result sits in the output register, so the block
//   cannot take a new word before it is through with the last one.
//   Reset empties the table at once (live bits clear), held speed 0, fallback
//   speed 42. No clearing pass is needed.
//   When the receiver stalls, the result waits in the output register and a
//   following item, once taken, holds its result until that register drains.
`default_nettype none

module timed_priority_speed_request_table #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TICK_MS     = 100
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // speed_value[7:0], valid_minutes[23:8], clears_queue[24]
    input  wire  [0:0]  s_axis_tuser,   // kind[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // accepted[0], current_speed[8:1], speed_changed[9]
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_END = CW'(QUEUE_DEPTH);
    localparam logic [tpsrt_pkg::MS_W-1:0] TICK_V = tpsrt_pkg::MS_W'(TICK_MS);

    tpsrt_pkg::t_state r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_dv;
    logic [IW-1:0]     r_didx;
    logic              r_kind;
    logic [7:0]        r_spd;
    logic [15:0]       r_minutes;
    logic              r_clr;
    logic              r_free_hit;
    logic [IW-1:0]     r_tgt;
    logic [7:0]        r_low;
    logic              r_any;
    logic [7:0]        r_best;
    logic [7:0]        r_held;
    logic [7:0]        r_fallback;
    logic              r_was_empty;
    logic [QUEUE_DEPTH-1:0] r_live;
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    logic              w_accept;
    logic              w_go;
    logic              w_free_any;
    logic [IW-1:0]     w_free_idx;
    logic [31:0]       w_ms;
    logic [31:0]       w_rem_dec;
    logic              w_replace;
    logic              w_acc;
    logic [7:0]        n_held;
    logic              w_chg;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    tpsrt_pkg::t_entry w_wdata;
    tpsrt_pkg::t_entry w_rdata;

    assign s_axis_tready = (r_state == tpsrt_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_go          = (r_state == tpsrt_pkg::S_FINISH) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (!r_live[k]) begin
                w_free_any = 1'b1;
                w_free_idx = IW'(k);
            end
        end
    end

    assign w_ms      = {16'd0, r_minutes} * tpsrt_pkg::MS_PER_MIN;
    assign w_rem_dec = (w_rdata.rem_ms > TICK_V) ? (w_rdata.rem_ms - TICK_V) : '0;
    assign w_replace = (r_minutes != '0) && (r_free_hit || (r_low < r_spd));

    always_comb begin
        n_held = r_held;
        w_acc  = 1'b0;
        if (r_kind == tpsrt_pkg::KIND_TICK) begin
            n_held = r_any ? r_best : r_fallback;
        end else begin
            w_acc = (r_minutes == '0) || w_replace;
        end
        w_chg = (n_held != r_held);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_didx;
        w_wdata.rem_ms = w_rem_dec;
        w_wdata.speed  = (w_rem_dec == '0) ? 8'd0 : w_rdata.speed;
        if ((r_state == tpsrt_pkg::S_SCAN) && r_dv &&
            (r_kind == tpsrt_pkg::KIND_TICK) && r_live[r_didx]) begin
            w_we = 1'b1;
        end else if (w_go && (r_kind == tpsrt_pkg::KIND_ADD) && w_replace) begin
            w_we           = 1'b1;
            w_waddr        = r_tgt;
            w_wdata.rem_ms = w_ms;
            w_wdata.speed  = r_spd;
        end
    end

    tpsrt_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpsrt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_live      <= '0;
            r_held      <= '0;
            r_fallback  <= tpsrt_pkg::FALLBACK_RESET;
            r_was_empty <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                tpsrt_pkg::S_IDLE: begin
                    r_dv <= 1'b0;
                    if (w_accept) begin
                        r_kind     <= s_axis_tuser[0];
                        r_spd      <= s_axis_tdata[7:0];
                        r_minutes  <= s_axis_tdata[23:8];
                        r_clr      <= s_axis_tdata[24];
                        r_free_hit <= w_free_any;
                        r_tgt      <= w_free_idx;
                        r_cnt      <= '0;
                        r_any      <= 1'b0;
                        r_best     <= '0;
                        r_low      <= '0;
                        if (s_axis_tuser[0] == tpsrt_pkg::KIND_TICK ||
                            (s_axis_tdata[23:8] != '0 && !w_free_any)) begin
                            r_state <= tpsrt_pkg::S_SCAN;
                        end else begin
                            r_state <= tpsrt_pkg::S_FINISH;
                        end
                    end
                end
                tpsrt_pkg::S_SCAN: begin
                    r_dv   <= (r_cnt < CNT_END);
                    r_didx <= r_cnt[IW-1:0];
                    if (r_cnt != CNT_END) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= tpsrt_pkg::S_FINISH;
                    end
                    if (r_dv) begin
                        if (r_kind == tpsrt_pkg::KIND_TICK) begin
                            if (r_live[r_didx]) begin
                                if (w_rem_dec == '0) begin
                                    r_live[r_didx] <= 1'b0;
                                end else begin
                                    r_any <= 1'b1;
                                    if (w_rdata.speed > r_best) begin
                                        r_best <= w_rdata.speed;
                                    end
                                end
                            end
                        end else if (r_didx == '0 || w_rdata.speed < r_low) begin
                            r_low <= w_rdata.speed;
                            r_tgt <= r_didx;
                        end
                    end
                end
                tpsrt_pkg::S_FINISH: begin
                    if (w_go) begin
                        r_out_data  <= {6'd0, w_chg, n_held, w_acc};
                        r_state     <= tpsrt_pkg::S_IDLE;
                        if (r_kind == tpsrt_pkg::KIND_TICK) begin
                            r_held <= n_held;
                            if (!r_any) begin
                                r_was_empty <= 1'b1;
                            end else if (r_was_empty) begin
                                r_was_empty <= 1'b0;
                                r_fallback  <= r_held;
                            end
                        end else if (r_minutes == '0) begin
                            r_fallback <= r_spd;
                            if (r_clr) begin
                                r_live <= '0;
                            end
                        end else if (w_replace) begin
                            r_live[r_tgt] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_dv    <= 1'b0;
                    r_state <= tpsrt_pkg::S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != tpsrt_pkg::S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpsrt_pkg::S_SCAN) |-> (r_cnt <= CNT_END))
        else $error("scan counter past table depth");

    a_add_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpsrt_pkg::S_SCAN && r_dv && r_kind == tpsrt_pkg::KIND_ADD) |-> (&r_live))
        else $error("replacement scan with a free slot");

    a_tick_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[9]) |-> !r_out_data[0])
        else $error("result word flags both change and accept");
`endif

endmodule

`default_nettype wire

>>> sim/speed_table_checker.sv
`timescale 1ns / 100ps
// Checker for the timed priority speed request table: watches both streams,
// keeps its own copy of the request table and compares every result word.
// Depends on tpsrt_pkg.

module speed_table_checker #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TICK_MS     = 100
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,  // speed_value[7:0], valid_minutes[23:8], clears_queue[24]
    input  wire  [0:0]  i_s_axis_tuser,  // kind[0]
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [15:0] i_m_axis_tdata,  // accepted[0], current_speed[8:1], speed_changed[9]
    output int          o_mismatches,
    output int          o_words_due
);

    typedef struct packed {
        logic                          changed;
        logic [tpsrt_pkg::SPEED_W-1:0] speed;
        logic                          accepted;
    } t_speed_word;

    logic                          slot_live  [QUEUE_DEPTH];
    logic [tpsrt_pkg::SPEED_W-1:0] slot_speed [QUEUE_DEPTH];
    logic [tpsrt_pkg::MS_W-1:0]    slot_ms    [QUEUE_DEPTH];
    logic [tpsrt_pkg::SPEED_W-1:0] held_speed;
    logic [tpsrt_pkg::SPEED_W-1:0] fallback_speed;
    logic                          table_was_empty;

    t_speed_word speed_words_due[$];
    int          mismatch_count = 0;
    int          due_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_words_due  = due_count;

    function automatic void empty_slots();
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_live[k]  = 1'b0;
            slot_speed[k] = '0;
            slot_ms[k]    = '0;
        end
    endfunction

    function automatic logic store_request(input logic [tpsrt_pkg::SPEED_W-1:0] spd,
                                           input logic [tpsrt_pkg::MIN_W-1:0] mins,
                                           input logic clr);
        logic [tpsrt_pkg::MS_W-1:0] ms;
        int                         low_idx;
        ms = 32'(mins) * tpsrt_pkg::MS_PER_MIN;
        if (mins == '0) begin
            fallback_speed = spd;
            if (clr)
                empty_slots();
            return 1'b1;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!slot_live[k]) begin
                slot_live[k]  = 1'b1;
                slot_speed[k] = spd;
                slot_ms[k]    = ms;
                return 1'b1;
            end
        end
        // table full: lowest speed, lowest index on a tie
        low_idx = 0;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            if (slot_speed[k] < slot_speed[low_idx])
                low_idx = k;
        end
        if (slot_speed[low_idx] < spd) begin
            slot_speed[low_idx] = spd;
            slot_ms[low_idx]    = ms;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic age_slots();
        logic                          any_live;
        logic [tpsrt_pkg::SPEED_W-1:0] best;
        logic [tpsrt_pkg::SPEED_W-1:0] prev;
        any_live = 1'b0;
        best     = '0;
        prev     = held_speed;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (slot_live[k]) begin
                if (slot_ms[k] > 32'(TICK_MS))
                    slot_ms[k] = slot_ms[k] - 32'(TICK_MS);
                else
                    slot_ms[k] = '0;
                if (slot_ms[k] == '0) begin
                    slot_live[k]  = 1'b0;
                    slot_speed[k] = '0;
                end else begin
                    if (!any_live || slot_speed[k] > best)
                        best = slot_speed[k];
                    any_live = 1'b1;
                end
            end
        end
        if (!any_live) begin
            table_was_empty = 1'b1;
            held_speed      = fallback_speed;
        end else begin
            // first entry seen: keep the speed held until now as fallback
            if (table_was_empty) begin
                table_was_empty = 1'b0;
                fallback_speed  = held_speed;
            end
            held_speed = best;
        end
        return prev != held_speed;
    endfunction

    function automatic t_speed_word predict_speed_word(input logic kind,
                                                       input logic [tpsrt_pkg::SPEED_W-1:0] spd,
                                                       input logic [tpsrt_pkg::MIN_W-1:0] mins,
                                                       input logic clr);
        t_speed_word word;
        word.accepted = 1'b0;
        word.changed  = 1'b0;
        if (kind == tpsrt_pkg::KIND_ADD)
            word.accepted = store_request(spd, mins, clr);
        else
            word.changed = age_slots();
        word.speed = held_speed;
        return word;
    endfunction

    always @(posedge i_clk) begin : watch
        t_speed_word seen;
        t_speed_word want;
        if (!i_rst_n) begin
            empty_slots();
            held_speed      = '0;
            fallback_speed  = tpsrt_pkg::FALLBACK_RESET;
            table_was_empty = 1'b1;
            speed_words_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen = i_m_axis_tdata[9:0];
                if (speed_words_due.size() == 0) begin
                    $display("%0t: result word with none due: expected nothing, actual %h",
                             $time, seen);
                    mismatch_count++;
                end else begin
                    want = speed_words_due.pop_front();
                    if (seen.accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.accepted, seen.accepted);
                        mismatch_count++;
                    end
                    if (seen.speed !== want.speed) begin
                        $display("%0t: current_speed expected %0d actual %0d",
                                 $time, want.speed, seen.speed);
                        mismatch_count++;
                    end
                    if (seen.changed !== want.changed) begin
                        $display("%0t: speed_changed expected %0b actual %0b",
                                 $time, want.changed, seen.changed);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                speed_words_due.push_back(predict_speed_word(i_s_axis_tuser[0],
                                                             i_s_axis_tdata[7:0],
                                                             i_s_axis_tdata[23:8],
                                                             i_s_axis_tdata[24]));
        end
        due_count = speed_words_due.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the speed request table testbench: clock, reset, request and tick
// stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on tpsrt_pkg, timed_priority_speed_request_table and speed_table_checker.

module testbench;

    localparam int QUEUE_DEPTH = 8;
    localparam int TICK_MS     = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // speed_value[7:0], valid_minutes[23:8], clears_queue[24]
    logic [0:0]  s_axis_tuser;   // kind[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // accepted[0], current_speed[8:1], speed_changed[9]

    int mismatches;
    int words_due;
    int words_sent = 0;
    int burst_left = 0;
    int ready_left = 0;

    timed_priority_speed_request_table #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TICK_MS    (TICK_MS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    speed_table_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TICK_MS    (TICK_MS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .o_mismatches   (mismatches),
        .o_words_due    (words_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    // receiver: alternate runs of ready and stall
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            if (m_axis_tready) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6);
            end else begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
            end
        end else begin
            ready_left--;
        end
    end

    // enter and leave at a falling edge
    task automatic push_word(input logic kind, input logic [7:0] spd,
                             input logic [15:0] mins, input logic clr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, clr, mins, spd};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        int          pick;
        logic        drained;
        logic [7:0]  spd;
        logic [15:0] mins;
        drained       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = $urandom_range(0, 20);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ticks, first entry, full table, ties, rejection, fallback
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd255, 16'd65535, 1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd0,   16'd1,     1'b1);
        push_word(tpsrt_pkg::KIND_TICK, 8'd255, 16'hFFFF,  1'b1);
        push_word(tpsrt_pkg::KIND_ADD,  8'd10,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd10,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd200, 16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd10,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd77,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd128, 16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd0,   16'd5,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd5,   16'd2,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd10,  16'd3,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd11,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd10,  16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd99,  16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd0,   16'd0,     1'b1);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd255, 16'd0,     1'b1);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);
        push_word(tpsrt_pkg::KIND_ADD,  8'd0,   16'd1,     1'b0);
        push_word(tpsrt_pkg::KIND_TICK, 8'd0,   16'd0,     1'b0);

        while (words_sent < 1100) begin
            pick = $urandom_range(0, 99);
            if (!drained && words_sent > 300) begin
                // clear, stagger one-minute entries, then tick until they expire
                push_word(tpsrt_pkg::KIND_ADD, 8'($urandom), 16'd0, 1'b1);
                repeat ($urandom_range(2, 5))
                    push_word(tpsrt_pkg::KIND_ADD, 8'($urandom), 16'd1, 1'($urandom));
                repeat ($urandom_range(20, 80))
                    push_word(tpsrt_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 6))
                    push_word(tpsrt_pkg::KIND_ADD, 8'($urandom), 16'd1, 1'($urandom));
                repeat (610)
                    push_word(tpsrt_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
                drained = 1'b1;
            end else if (pick < 35) begin
                repeat ($urandom_range(1, 10)) begin
                    spd  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3) * 64)
                                                       : 8'($urandom);
                    mins = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(1, 3));
                    push_word(tpsrt_pkg::KIND_ADD, spd, mins, 1'($urandom));
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 15))
                    push_word(tpsrt_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 85) begin
                push_word(tpsrt_pkg::KIND_ADD, 8'($urandom), 16'd0, 1'($urandom));
            end else if (pick < 95) begin
                push_word(1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                push_word(tpsrt_pkg::KIND_ADD, 8'($urandom), 16'd0, 1'b1);
                repeat ($urandom_range(1, 4))
                    push_word(tpsrt_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (words_due != 0) @(posedge i_clk);
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
src/tpsrt_pkg.sv
src/tpsrt_mem.sv
src/timed_priority_speed_request_table.sv
sim/speed_table_checker.sv
sim/testbench.sv
